### hw/rtl/assert_macros.svh
// Assertion macros used by the deque datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/deq_pkg.sv
// Types, constants and ring helpers for the double-ended queue
`default_nettype none

package deq_pkg;

  localparam int CAPACITY = 256;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_CLEAR      = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_word;
    logic [8:0]               count;
    logic                     is_empty;
    logic [1:0]               status;
  } out_t;

  typedef struct packed {
    logic accept;
    logic load_pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic needs_read;
  } dp_status_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(CAPACITY - 1)) ? '0 : i + IDX_W'(1);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == '0) ? IDX_W'(CAPACITY - 1) : i - IDX_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/deq_ctrl.sv
// Controller state machine: transaction acceptance and pop read sequencing
`default_nettype none

module deq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   out_ready,
  input  wire deq_pkg::dp_status_t    dp_status,
  output deq_pkg::ctrl_cmd_t          cmd
);

  deq_pkg::state_t state_r;
  deq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      deq_pkg::ST_IDLE: begin
        if (cmd.accept && dp_status.needs_read) begin
          state_nxt = deq_pkg::ST_READ;
        end
      end
      deq_pkg::ST_READ: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load_pop = 1'b0;
    case (state_r)
      deq_pkg::ST_IDLE: begin
        in_ready = !dp_status.out_busy || out_ready;
      end
      deq_pkg::ST_READ: begin
        cmd.load_pop = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.accept = in_valid && in_ready;
  end

endmodule

`default_nettype wire

### hw/rtl/deq_datapath.sv
// Datapath: ring pointers, word count, store access and result register
`default_nettype none
`include "assert_macros.svh"

module deq_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire deq_pkg::in_t           in_data,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output deq_pkg::out_t               out_data,
  input  wire deq_pkg::ctrl_cmd_t     cmd,
  output deq_pkg::dp_status_t         dp_status
);

  logic [deq_pkg::IDX_W-1:0]  front_r;
  logic [deq_pkg::IDX_W-1:0]  front_nxt;
  logic [deq_pkg::IDX_W-1:0]  back_r;
  logic [deq_pkg::IDX_W-1:0]  back_nxt;
  logic [deq_pkg::CNT_W-1:0]  cnt_r;
  logic [deq_pkg::CNT_W-1:0]  cnt_nxt;
  logic                       out_valid_r;
  deq_pkg::out_t              out_data_r;
  logic                       full;
  logic                       empty;
  logic                       needs_read;
  logic [1:0]                 res_status;
  logic                       ram_we;
  logic [deq_pkg::IDX_W-1:0]  ram_waddr;
  logic [deq_pkg::IDX_W-1:0]  ram_raddr;
  logic [deq_pkg::WORD_W-1:0] ram_rdata;

  assign full  = (cnt_r == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
  assign empty = (cnt_r == '0);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    cnt_nxt    = cnt_r;
    needs_read = 1'b0;
    res_status = deq_pkg::STATUS_OK;
    ram_we     = 1'b0;
    ram_waddr  = back_r;
    ram_raddr  = front_r;
    case (in_data.mode)
      deq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          res_status = deq_pkg::STATUS_PUSH_FULL;
        end else begin
          front_nxt = deq_pkg::ring_prev(front_r);
          ram_waddr = front_nxt;
          ram_we    = cmd.accept;
          cnt_nxt   = cnt_r + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          res_status = deq_pkg::STATUS_PUSH_FULL;
        end else begin
          ram_waddr = back_r;
          ram_we    = cmd.accept;
          back_nxt  = deq_pkg::ring_next(back_r);
          cnt_nxt   = cnt_r + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          res_status = deq_pkg::STATUS_POP_EMPTY;
        end else begin
          ram_raddr  = front_r;
          front_nxt  = deq_pkg::ring_next(front_r);
          cnt_nxt    = cnt_r - deq_pkg::CNT_W'(1);
          needs_read = 1'b1;
        end
      end
      deq_pkg::MODE_POP_BACK: begin
        if (empty) begin
          res_status = deq_pkg::STATUS_POP_EMPTY;
        end else begin
          back_nxt   = deq_pkg::ring_prev(back_r);
          ram_raddr  = back_nxt;
          cnt_nxt    = cnt_r - deq_pkg::CNT_W'(1);
          needs_read = 1'b1;
        end
      end
      deq_pkg::MODE_CLEAR: begin
        front_nxt = '0;
        back_nxt  = '0;
        cnt_nxt   = '0;
      end
      default: begin
        res_status = deq_pkg::STATUS_OK;
      end
    endcase
  end

  deq_ram #(
    .WIDTH(deq_pkg::WORD_W),
    .DEPTH(deq_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data.value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
        cnt_r   <= cnt_nxt;
      end
      if ((cmd.accept && !needs_read) || cmd.load_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data_r.popped_word <= '0;
      out_data_r.count       <= 9'(cnt_nxt);
      out_data_r.is_empty    <= (cnt_nxt == '0);
      out_data_r.status      <= res_status;
    end else if (cmd.load_pop) begin
      out_data_r.popped_word <= ram_rdata;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data             = out_data_r;
  assign dp_status.out_busy   = out_valid_r;
  assign dp_status.needs_read = needs_read;

  `ASSERT_NEVER(a_cnt_bound, cnt_r > deq_pkg::CNT_W'(deq_pkg::CAPACITY), "count above capacity")
  `ASSERT_CLK(a_pop_load, cmd.accept && needs_read |=> cmd.load_pop, "pop read not loaded")
  `ASSERT_CLK(a_no_overwrite, cmd.accept |-> !out_valid_r || out_ready, "result overwritten")
  `ASSERT_CLK(a_load_free, cmd.load_pop |-> !out_valid_r, "pop loaded into busy result")

endmodule

`default_nettype wire

### hw/rtl/double_ended_queue.sv
// Double-ended queue top level: controller, datapath and word store
// Holds up to 256 signed 32-bit words in a ring store addressed by front and back
// pointers. Each input transaction carries one operation (push front, push back, pop
// front, pop back, clear) and returns exactly one result transaction with the popped
// word, the count after the operation, an empty flag and a status (pop on empty and
// push on full are flagged and leave the queue unchanged; mode codes five to seven do
// nothing). Pushes, clears, no-ops and rejected operations load their result on
// acceptance; a pop that removes a word loads its popped word in the read state,
// after the registered read of the store RAM. A new transaction enters only in the
// idle state, while the result register is empty or in the cycle that its result is
// taken. The store is not cleared at reset or by clear; only written entries are read.
`default_nettype none

module double_ended_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire deq_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output deq_pkg::out_t       out_data
);

  deq_pkg::ctrl_cmd_t  cmd;
  deq_pkg::dp_status_t dp_status;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .dp_status(dp_status),
    .cmd      (cmd)
  );

  deq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .dp_status(dp_status)
  );

endmodule

`default_nettype wire
